// File: design/lse_pkg.sv
// shared types and constants of the lsb stego extractor
`default_nettype none
package lse_pkg;

	localparam int DIM_BITS_DEF   = 11;
	localparam int COUNT_BITS_DEF = 16;

	localparam logic [1:0] MODE_BAD   = 2'b00;
	localparam logic [1:0] MODE_TEXT  = 2'b01;
	localparam logic [1:0] MODE_IMAGE = 2'b10;
	localparam logic [1:0] MODE_RSVD  = 2'b11;

	localparam logic [7:0] MARKER = 8'h78;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		KIND_CHAR     = 3'd0,
		KIND_PIXEL    = 3'd1,
		KIND_EMPTY    = 3'd2,
		KIND_NOT_ENC  = 3'd3,
		KIND_BAD_CODE = 3'd4,
		KIND_UNSUPP   = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_HEADER = 2'd1,
		PH_DATA   = 2'd2
	} phase_t;

endpackage
`default_nettype wire

// File: design/lsb_stego_extractor.sv
// lsb stego extractor top level: config registers, input stage, decoder, result register
// Usage:
//   s_* carries the channel bytes of a stego image in raster R,G,B order, with
//   s_tuser high on the first byte of each image; that byte holds the mode code.
//   m_* carries decoded results: characters in text mode, rebuilt pixels in
//   image mode, or a status kind; m_tlast marks the final result of an image.
//   Most bytes produce no result; a byte produces at most one.
//   cfg_we/cfg_index/cfg_wdata write the expected cover width (index 0) and
//   height (index 1); write them only while the block is idle.
// Timing:
//   one byte per cycle sustained while m_* is not stalled; a byte accepted on s_*
//   reaches m_* through the input register, then one decode step into the result
//   register.
// Reset:
//   arst_n clears the decode state to idle and both config registers to zero.
// Stall:
//   a held result stays on m_* until taken; one more byte waits in the input
//   register, and then s_tready drops until the result register drains.
`default_nettype none
module lsb_stego_extractor import lse_pkg::*; #(
	parameter int DIM_BITS   = DIM_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [DIM_BITS-1:0] cfg_wdata,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [7:0]          s_tdata,   // channel_value
	input  wire logic                s_tuser,   // first_of_image
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// char_or_red, green, blue, pixel_x, pixel_y, zero pad
	output logic [((24+2*DIM_BITS+7)/8)*8-1:0] m_tdata,
	output logic [2:0]               m_tuser,   // kind
	output logic                     m_tlast
);

	localparam int OUT_W = ((24 + 2 * DIM_BITS + 7) / 8) * 8;

	logic [DIM_BITS-1:0] image_width_q, image_height_q;
	logic                valid_s1, first_s1, fire;
	logic [7:0]          ch_s1;
	logic                res_valid, res_last;
	kind_t               res_kind;
	logic [7:0]          res_red, res_green, res_blue;
	logic [DIM_BITS-1:0] res_x, res_y;
	logic                valid_s2, last_s2;
	kind_t               kind_s2;
	logic [7:0]          red_s2, green_s2, blue_s2;
	logic [DIM_BITS-1:0] x_s2, y_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= '0;
			image_height_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_IMAGE_HEIGHT)
				image_height_q <= cfg_wdata;
			else
				image_width_q <= cfg_wdata;
		end
	end

	assign fire = valid_s1 && (!valid_s2 || m_tready);

	lse_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.advance  (fire),
		.valid_s1 (valid_s1),
		.ch_s1    (ch_s1),
		.first_s1 (first_s1)
	);

	lse_decoder #(
		.DIM_BITS   (DIM_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dec (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.ch           (ch_s1),
		.first        (first_s1),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.res_valid    (res_valid),
		.res_kind     (res_kind),
		.res_red      (res_red),
		.res_green    (res_green),
		.res_blue     (res_blue),
		.res_x        (res_x),
		.res_y        (res_y),
		.res_last     (res_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= res_valid;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			kind_s2  <= res_kind;
			red_s2   <= res_red;
			green_s2 <= res_green;
			blue_s2  <= res_blue;
			x_s2     <= res_x;
			y_s2     <= res_y;
			last_s2  <= res_last;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = kind_s2;
	assign m_tlast  = last_s2;
	assign m_tdata  = OUT_W'({y_s2, x_s2, blue_s2, green_s2, red_s2});

	// status kinds always close the image
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_CHAR && m_tuser != KIND_PIXEL |-> m_tlast)
		else $error("status result without last");

	// only pixels carry green, blue and position
	a_nonpixel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_PIXEL |-> m_tdata[OUT_W-1:8] == '0)
		else $error("non-pixel result with pixel fields set");

	// a mode byte with code 00 reports a bad code on the next cycle
	a_bad_code: assert property (@(posedge clk) disable iff (!arst_n)
		fire && first_s1 && ch_s1[1:0] == MODE_BAD |=>
		m_tvalid && m_tuser == KIND_BAD_CODE && m_tlast)
		else $error("bad mode code not reported");

endmodule
`default_nettype wire

// File: design/lse_in_stage.sv
// input register of the stream slave side
`default_nettype none
module lse_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // channel_value
	input  wire logic       s_tuser,   // first_of_image
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      ch_s1,
	output logic            first_s1
);

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1    <= s_tdata;
			first_s1 <= s_tuser;
		end
	end

endmodule
`default_nettype wire

// File: design/lse_decoder.sv
// decode state and per-byte next-state and result logic
`default_nettype none
module lse_decoder import lse_pkg::*; #(
	parameter int DIM_BITS   = DIM_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                fire,
	input  wire logic [7:0]          ch,
	input  wire logic                first,
	input  wire logic [DIM_BITS-1:0] image_width,
	input  wire logic [DIM_BITS-1:0] image_height,
	output logic                     res_valid,
	output kind_t                    res_kind,
	output logic [7:0]               res_red,
	output logic [7:0]               res_green,
	output logic [7:0]               res_blue,
	output logic [DIM_BITS-1:0]      res_x,
	output logic [DIM_BITS-1:0]      res_y,
	output logic                     res_last
);

	localparam int COVER_END = 2 + DIM_BITS + 8 + DIM_BITS;
	localparam int TEXT_END  = COVER_END + COUNT_BITS;
	localparam int IMG_USED  = COVER_END + 2 * DIM_BITS;
	localparam int IMG_TOTAL = (IMG_USED > 72) ? IMG_USED : 72;
	localparam int CNT_W     = $clog2(IMG_TOTAL + 1);
	localparam int HDR_W     = (2 * DIM_BITS + 8 > COUNT_BITS) ? 2 * DIM_BITS + 8 : COUNT_BITS;

	phase_t                phase_q, phase_d;
	logic [1:0]            mode_q, mode_d;
	logic [HDR_W-1:0]      hdr_q, hdr_d, hdr_v;
	logic [CNT_W-1:0]      cnt_q, cnt_d, cnt_v;
	logic                  cover_ok_q, cover_ok_d, cover_v;
	logic [COUNT_BITS-1:0] chars_q, chars_d, chars_v;
	logic [7:0]            acc_q, acc_d, acc_v;
	logic [1:0]            chan_q, chan_d;
	logic [7:0]            red_q, red_d, green_q, green_d;
	logic [DIM_BITS-1:0]   hx_q, hx_d, hy_q, hy_d, hw_q, hw_d, hh_q, hh_d;
	logic [DIM_BITS:0]     x1, y1;
	logic                  hdr_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			mode_q     <= MODE_BAD;
			hdr_q      <= '0;
			cnt_q      <= '0;
			cover_ok_q <= 1'b0;
			chars_q    <= '0;
			acc_q      <= '0;
			chan_q     <= CH_RED;
			red_q      <= '0;
			green_q    <= '0;
			hx_q       <= '0;
			hy_q       <= '0;
			hw_q       <= '0;
			hh_q       <= '0;
		end else begin
			phase_q    <= phase_d;
			mode_q     <= mode_d;
			hdr_q      <= hdr_d;
			cnt_q      <= cnt_d;
			cover_ok_q <= cover_ok_d;
			chars_q    <= chars_d;
			acc_q      <= acc_d;
			chan_q     <= chan_d;
			red_q      <= red_d;
			green_q    <= green_d;
			hx_q       <= hx_d;
			hy_q       <= hy_d;
			hw_q       <= hw_d;
			hh_q       <= hh_d;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		mode_d     = mode_q;
		hdr_d      = hdr_q;
		cnt_d      = cnt_q;
		cover_ok_d = cover_ok_q;
		chars_d    = chars_q;
		acc_d      = acc_q;
		chan_d     = chan_q;
		red_d      = red_q;
		green_d    = green_q;
		hx_d       = hx_q;
		hy_d       = hy_q;
		hw_d       = hw_q;
		hh_d       = hh_q;
		hdr_v      = hdr_q;
		cnt_v      = cnt_q;
		cover_v    = cover_ok_q;
		chars_v    = chars_q;
		acc_v      = acc_q;
		x1         = {1'b0, hx_q} + 1'b1;
		y1         = {1'b0, hy_q};
		hdr_done   = 1'b0;
		res_valid  = 1'b0;
		res_kind   = KIND_CHAR;
		res_red    = '0;
		res_green  = '0;
		res_blue   = '0;
		res_x      = '0;
		res_y      = '0;
		res_last   = 1'b0;

		if (fire) begin
			if (first) begin
				mode_d     = ch[1:0];
				hdr_d      = '0;
				cnt_d      = CNT_W'(2);
				cover_ok_d = 1'b0;
				phase_d    = PH_HEADER;
				case (ch[1:0])
					MODE_BAD: begin
						res_valid = 1'b1;
						res_kind  = KIND_BAD_CODE;
						res_last  = 1'b1;
					end
					MODE_RSVD: begin
						res_valid = 1'b1;
						res_kind  = KIND_UNSUPP;
						res_last  = 1'b1;
					end
					default: ;
				endcase
			end else begin
				case (phase_q)
					PH_HEADER: begin
						if (mode_q == MODE_TEXT) begin
							hdr_v = {hdr_q[HDR_W-2:0], ch[0]};
							cnt_v = cnt_q + CNT_W'(1);
						end else begin
							if (cnt_q < CNT_W'(IMG_USED))
								hdr_v = {hdr_q[HDR_W-3:0], ch[1:0]};
							cnt_v = cnt_q + CNT_W'(2);
						end
						if (cnt_v == CNT_W'(COVER_END)) begin
							cover_v = (hdr_v[2*DIM_BITS+7:DIM_BITS+8] == image_width) &&
								(hdr_v[DIM_BITS+7:DIM_BITS] == MARKER) &&
								(hdr_v[DIM_BITS-1:0] == image_height);
							hdr_v = '0;
						end
						hdr_d      = hdr_v;
						cnt_d      = cnt_v;
						cover_ok_d = cover_v;
						if (mode_q == MODE_TEXT)
							hdr_done = (cnt_v == CNT_W'(TEXT_END));
						else
							hdr_done = (cnt_v == CNT_W'(IMG_TOTAL));
						if (hdr_done) begin
							if (!cover_v) begin
								res_valid = 1'b1;
								res_kind  = KIND_NOT_ENC;
								res_last  = 1'b1;
							end else begin
								phase_d = PH_DATA;
								cnt_d   = '0;
								acc_d   = '0;
								chars_d = hdr_v[COUNT_BITS-1:0];
								chan_d  = CH_RED;
								hx_d    = '0;
								hy_d    = '0;
								hw_d    = hdr_v[2*DIM_BITS-1:DIM_BITS];
								hh_d    = hdr_v[DIM_BITS-1:0];
							end
						end
					end
					PH_DATA: begin
						if (mode_q == MODE_TEXT) begin
							acc_v = {acc_q[6:0], ch[0]};
							cnt_v = cnt_q + CNT_W'(1);
							acc_d = acc_v;
							if (cnt_v >= CNT_W'(8)) begin
								cnt_d     = '0;
								chars_v   = (chars_q != '0) ? chars_q - 1'b1 : chars_q;
								chars_d   = chars_v;
								res_valid = 1'b1;
								res_kind  = KIND_CHAR;
								res_red   = acc_v;
								res_last  = (chars_v == '0);
							end else begin
								cnt_d = cnt_v;
								if (chars_q == '0) begin
									res_valid = 1'b1;
									res_kind  = KIND_EMPTY;
									res_last  = 1'b1;
								end
							end
						end else begin
							acc_v = {acc_q[5:0], ch[1:0]};
							cnt_v = cnt_q + CNT_W'(2);
							acc_d = acc_v;
							if (cnt_v < CNT_W'(8)) begin
								cnt_d = cnt_v;
							end else begin
								cnt_d = '0;
								case (chan_q)
									CH_RED: begin
										red_d  = acc_v;
										chan_d = CH_GREEN;
									end
									CH_GREEN: begin
										green_d = acc_v;
										chan_d  = CH_BLUE;
									end
									default: begin
										chan_d = CH_RED;
										if (x1 >= {1'b0, hw_q}) begin
											hx_d = '0;
											y1   = {1'b0, hy_q} + 1'b1;
										end else begin
											hx_d = x1[DIM_BITS-1:0];
										end
										hy_d      = y1[DIM_BITS-1:0];
										res_valid = 1'b1;
										res_kind  = KIND_PIXEL;
										res_red   = red_q;
										res_green = green_q;
										res_blue  = acc_v;
										res_x     = hx_q;
										res_y     = hy_q;
										res_last  = (y1 >= {1'b0, hh_q});
									end
								endcase
							end
						end
					end
					default: ;
				endcase
			end
			if (res_valid && res_last)
				phase_d = PH_IDLE;
		end
	end

endmodule
`default_nettype wire
